// ----- rtl/hss_pkg.sv -----
`timescale 1ns / 1ps
package hss_pkg;

  localparam int MAX_STEPS = 16;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [18:0] DEG16_TO_Q12 = 19'd292818;
  localparam logic signed [17:0] PI_Q12 = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic signed [17:0] FOUR_PI_Q12 = 18'sd51472;
  localparam logic [14:0] SPEED_MAX = 15'd16384;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_START = 2'd2,
    FUNC_STOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DIR_FWD   = 2'd0,
    DIR_BACK  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    EV_IDLE          = 4'd0,
    EV_TURNING       = 4'd1,
    EV_DRIVING       = 4'd2,
    EV_DRIVE_TIMEOUT = 4'd3,
    EV_STEP_DONE     = 4'd4,
    EV_COMPLETE      = 4'd5,
    EV_IMU_ABORT     = 4'd6,
    EV_START_REFUSED = 4'd7,
    EV_STARTED       = 4'd8,
    EV_STOPPED       = 4'd9,
    EV_LOADED        = 4'd10
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURN_GAIN   = 3'd0,
    REG_OMEGA_LIMIT = 3'd1,
    REG_HEADING_TOL = 3'd2,
    REG_TURN_TMO    = 3'd3,
    REG_DEF_SPEED   = 3'd4,
    REG_PROG_LEN    = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WRAP,
    ST_GAIN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [1:0]         dir;
    logic [14:0]        speed;
    logic signed [13:0] heading;
    logic [19:0]        duration;
  } hss_entry_t;

  typedef struct packed {
    logic               in_tol;
    logic signed [15:0] omega;
  } hss_steer_t;

endpackage

// ----- rtl/hss_steer_unit.sv -----
`timescale 1ns / 1ps
module hss_steer_unit
  import hss_pkg::*;
(
  input  logic               clk,
  input  logic signed [13:0] step_heading,
  input  logic signed [14:0] heading_now,
  input  logic [15:0]        turn_gain,
  input  logic [14:0]        omega_limit,
  input  logic [13:0]        heading_tolerance,
  output hss_steer_t         steer
);

  // stage 1: target magnitude times degree scale
  logic [13:0]        hmag;
  logic [32:0]        prod1;
  logic               hneg1;
  logic signed [14:0] hnow1;

  // stage 2: round, subtract, wrap
  logic [32:0]        sum1;
  logic [16:0]        tgt_mag;
  logic signed [17:0] tgt;
  logic signed [17:0] err;
  logic signed [17:0] err_a;
  logic signed [17:0] err_w;
  logic signed [14:0] err2;

  // stage 3: gain multiply
  logic               neg2;
  logic [14:0]        mag15;
  logic [13:0]        aerr;
  logic [29:0]        prod2;
  logic               neg3;
  logic               within3;

  // stage 4: round and clamp
  logic [29:0]        sum2;
  logic [17:0]        wmag;
  logic [17:0]        lim18;
  logic [17:0]        wclamp;
  logic signed [15:0] wpos;

  always_comb begin
    hmag = step_heading[13] ? 14'(-step_heading) : 14'(step_heading);
  end

  always_ff @(posedge clk) begin
    prod1 <= 33'(hmag) * 33'(DEG16_TO_Q12);
    hneg1 <= step_heading[13];
    hnow1 <= heading_now;
  end

  always_comb begin
    sum1 = prod1 + 33'd32768;
    tgt_mag = sum1[32:16];
    tgt = hneg1 ? -$signed({1'b0, tgt_mag}) : $signed({1'b0, tgt_mag});
    err = tgt - $signed({{3{hnow1[14]}}, hnow1});
    err_a = err;
    err_w = err;
    if (err > PI_Q12) begin
      err_a = err - TWO_PI_Q12;
      err_w = (err_a > PI_Q12) ? (err - FOUR_PI_Q12) : err_a;
    end else if (err < -PI_Q12) begin
      err_a = err + TWO_PI_Q12;
      err_w = (err_a < -PI_Q12) ? (err + FOUR_PI_Q12) : err_a;
    end
  end

  always_ff @(posedge clk) begin
    err2 <= err_w[14:0];
  end

  always_comb begin
    neg2 = err2[14];
    mag15 = neg2 ? 15'(-err2) : 15'(err2);
    aerr = mag15[13:0];
  end

  always_ff @(posedge clk) begin
    prod2 <= 30'(turn_gain) * 30'(aerr);
    neg3 <= neg2;
    within3 <= (aerr <= heading_tolerance);
  end

  always_comb begin
    sum2 = prod2 + 30'd2048;
    wmag = sum2[29:12];
    lim18 = 18'(omega_limit);
    wclamp = (wmag > lim18) ? lim18 : wmag;
    wpos = $signed({1'b0, wclamp[14:0]});
    steer.in_tol = within3;
    steer.omega = neg3 ? -wpos : wpos;
  end

endmodule

// ----- rtl/heading_step_sequencer_top.sv -----
`timescale 1ns / 1ps
// channel  | handshake                     | payload
// ---------+-------------------------------+-----------------------------------------
// command  | start, busy (accept: start&!busy) | func, now_ms, heading_now, imu_ok,
//          |                               | slot, step_dir, step_speed,
//          |                               | step_heading, step_duration_ms
// result   | done (one-cycle strobe)       | vx, vy, omega, drive_valid, stop_motors,
//          |                               | reset_regulators, step_index, running,
//          |                               | event_res
// config   | cfg_valid, cfg_ready          | cfg_index, cfg_data
//
// a command runs from accept to done through step table read, heading scale
// multiply, wrap, gain multiply and clamp
// busy stays high while a command is in flight and falls as done rises: one command at a time
// config writes wait while a command is offered or in flight
// reset clears control state; the step table is not cleared
// done lasts one cycle; the receiver cannot stall it
module heading_step_sequencer_top
  import hss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func,
  input  logic [31:0]           now_ms,
  input  logic signed [14:0]    heading_now,
  input  logic                  imu_ok,
  input  logic [3:0]            slot,
  input  logic [1:0]            step_dir,
  input  logic [14:0]           step_speed,
  input  logic signed [13:0]    step_heading,
  input  logic [19:0]           step_duration_ms,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic signed [15:0]    vx,
  output logic signed [15:0]    vy,
  output logic signed [15:0]    omega,
  output logic                  drive_valid,
  output logic                  stop_motors,
  output logic                  reset_regulators,
  output logic signed [5:0]     step_index,
  output logic                  running,
  output logic [3:0]            event_res
);

  localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  state_t state, state_next;

  logic [15:0] turn_gain;
  logic [14:0] omega_limit;
  logic [13:0] heading_tolerance;
  logic [19:0] turn_timeout_ms;
  logic [14:0] default_speed;
  logic [4:0]  program_length;

  logic signed [5:0] cur, cur_next;
  logic              in_drive, in_drive_next;
  logic [31:0]       phase_start, phase_start_next;
  logic              is_running, is_running_next;

  hss_entry_t step_mem [MAX_STEPS];
  hss_entry_t rd_q;
  hss_entry_t wr_entry;

  func_t              func_q;
  logic [31:0]        now_q;
  logic signed [14:0] hnow_q;
  logic               imu_q;

  logic        accept;
  logic [31:0] slot_ext;
  logic [31:0] cur_ext;
  logic        slot_ok;
  logic [AW-1:0] slot_addr;
  logic [AW-1:0] cur_addr;
  logic [4:0]  eff_len;
  logic        cur_bad;

  logic [31:0] elapsed_q;
  logic        timed_q;
  logic        dur_done_q;
  logic        dur_zero_q;

  hss_steer_t steer;

  logic [14:0]        spd;
  logic signed [15:0] spd_s;
  logic               go_drive;
  logic               tmo_turn;
  logic               step_done;

  logic signed [15:0] vx_next, vy_next, om_next;
  logic               dv_next, stop_next, rreg_next;
  event_t             ev_next;

  assign accept = start && !busy;
  assign busy = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !start;

  always_comb begin
    slot_ext = 32'(slot);
    slot_ok = (slot_ext < 32'(MAX_STEPS));
    slot_addr = slot_ext[AW-1:0];
    cur_ext = 32'(cur[4:0]);
    cur_addr = cur_ext[AW-1:0];
    eff_len = (32'(program_length) < 32'(MAX_STEPS)) ? program_length : 5'(MAX_STEPS);
    cur_bad = cur[5] || (cur[4:0] >= eff_len);
    wr_entry.dir = step_dir;
    wr_entry.speed = step_speed;
    wr_entry.heading = step_heading;
    wr_entry.duration = step_duration_ms;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_gain <= 16'd4096;
      omega_limit <= 15'd8192;
      heading_tolerance <= 14'd357;
      turn_timeout_ms <= 20'd3000;
      default_speed <= 15'd8192;
      program_length <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TURN_GAIN:   turn_gain <= cfg_data[15:0];
        REG_OMEGA_LIMIT: omega_limit <= cfg_data[14:0];
        REG_HEADING_TOL: heading_tolerance <= cfg_data[13:0];
        REG_TURN_TMO:    turn_timeout_ms <= cfg_data[19:0];
        REG_DEF_SPEED:   default_speed <= cfg_data[14:0];
        REG_PROG_LEN:    program_length <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // step table
  always_ff @(posedge clk) begin
    if (accept) begin
      if ((func_t'(func) == FUNC_LOAD) && slot_ok) begin
        step_mem[slot_addr] <= wr_entry;
      end
      rd_q <= step_mem[cur_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func_t'(func);
      now_q <= now_ms;
      hnow_q <= heading_now;
      imu_q <= imu_ok;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_q <= now_q - phase_start;
    timed_q <= (elapsed_q > 32'(turn_timeout_ms));
    dur_done_q <= (elapsed_q >= 32'(rd_q.duration));
    dur_zero_q <= (rd_q.duration == 20'd0);
  end

  hss_steer_unit u_steer (
    .clk               (clk),
    .step_heading      (rd_q.heading),
    .heading_now       (hnow_q),
    .turn_gain         (turn_gain),
    .omega_limit       (omega_limit),
    .heading_tolerance (heading_tolerance),
    .steer             (steer)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_WRAP;
      ST_WRAP:   state_next = ST_GAIN;
      ST_GAIN:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    spd = (rd_q.speed != 15'd0) ? rd_q.speed : default_speed;
    if (spd > SPEED_MAX) spd = SPEED_MAX;
    spd_s = $signed({1'b0, spd});
    cur_next = cur;
    in_drive_next = in_drive;
    phase_start_next = phase_start;
    is_running_next = is_running;
    vx_next = '0;
    vy_next = '0;
    om_next = '0;
    dv_next = 1'b0;
    stop_next = 1'b0;
    rreg_next = 1'b0;
    ev_next = EV_IDLE;
    go_drive = 1'b0;
    tmo_turn = 1'b0;
    step_done = 1'b0;
    unique case (func_q)
      FUNC_LOAD: begin
        cur_next = -6'sd1;
        is_running_next = 1'b0;
        ev_next = EV_LOADED;
      end
      FUNC_START: begin
        if (eff_len == 5'd0) begin
          ev_next = EV_START_REFUSED;
        end else begin
          cur_next = 6'sd0;
          in_drive_next = 1'b0;
          phase_start_next = now_q;
          is_running_next = 1'b1;
          ev_next = EV_STARTED;
        end
      end
      FUNC_STOP: begin
        cur_next = -6'sd1;
        is_running_next = 1'b0;
        stop_next = 1'b1;
        rreg_next = 1'b1;
        ev_next = EV_STOPPED;
      end
      FUNC_TICK: begin
        priority if (!is_running) begin
          ev_next = EV_IDLE;
        end else if (!imu_q) begin
          cur_next = -6'sd1;
          is_running_next = 1'b0;
          stop_next = 1'b1;
          rreg_next = 1'b1;
          ev_next = EV_IMU_ABORT;
        end else if (cur_bad) begin
          cur_next = -6'sd1;
          is_running_next = 1'b0;
          stop_next = 1'b1;
          rreg_next = 1'b1;
          ev_next = EV_COMPLETE;
        end else begin
          go_drive = 1'b1;
          step_done = dur_done_q;
          if (!in_drive) begin
            if (!steer.in_tol && !timed_q) begin
              om_next = steer.omega;
              dv_next = 1'b1;
              ev_next = EV_TURNING;
              go_drive = 1'b0;
            end else begin
              tmo_turn = timed_q && !steer.in_tol;
              in_drive_next = 1'b1;
              phase_start_next = now_q;
              step_done = dur_zero_q;
            end
          end
          if (go_drive) begin
            if (step_done) begin
              cur_next = cur + 6'sd1;
              in_drive_next = 1'b0;
              phase_start_next = now_q;
              rreg_next = 1'b1;
              ev_next = EV_STEP_DONE;
            end else begin
              unique case (dir_t'(rd_q.dir))
                DIR_FWD:   vy_next = spd_s;
                DIR_BACK:  vy_next = -spd_s;
                DIR_LEFT:  vx_next = -spd_s;
                DIR_RIGHT: vx_next = spd_s;
                default:   vx_next = spd_s;
              endcase
              om_next = steer.omega;
              dv_next = 1'b1;
              ev_next = tmo_turn ? EV_DRIVE_TIMEOUT : EV_DRIVING;
            end
          end
        end
      end
      default: ev_next = EV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= -6'sd1;
      in_drive <= 1'b0;
      phase_start <= '0;
      is_running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (state == ST_DECIDE);
      if (state == ST_DECIDE) begin
        cur <= cur_next;
        in_drive <= in_drive_next;
        phase_start <= phase_start_next;
        is_running <= is_running_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE) begin
      vx <= vx_next;
      vy <= vy_next;
      omega <= om_next;
      drive_valid <= dv_next;
      stop_motors <= stop_next;
      reset_regulators <= rreg_next;
      step_index <= cur_next;
      running <= is_running_next;
      event_res <= ev_next;
    end
  end

endmodule
